[hw/rtl/signed_to_custom_radix_digits_macros.svh]
// ----------------------------------------------------------------------------
// signed_to_custom_radix_digits assertion macros
// Shared concurrent assertion forms, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef SIGNED_TO_CUSTOM_RADIX_DIGITS_MACROS_SVH
`define SIGNED_TO_CUSTOM_RADIX_DIGITS_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define STCRD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("stcrd assertion failed");
// next-cycle implication
`define STCRD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("stcrd assertion failed");
`else
`define STCRD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define STCRD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[hw/rtl/stcrd_pkg.sv]
// ----------------------------------------------------------------------------
// stcrd_pkg
// Types and constants shared by the custom radix digit converter.
// ----------------------------------------------------------------------------
package stcrd_pkg;

  localparam int DEF_MAX_BASE    = 128;
  localparam int DEF_VALUE_BITS  = 32;
  localparam int DEF_DIGIT_DEPTH = 32;

  localparam int SYM_W       = 7;
  localparam int ALPHA_DEPTH = 128;
  localparam int CNT_W       = 8;

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_APPEND  = 2'd1;
  localparam logic [1:0] OP_CONVERT = 2'd2;

  localparam logic [7:0] SYM_PLUS  = 8'h2B;
  localparam logic [7:0] SYM_MINUS = 8'h2D;
  localparam logic [7:0] SYM_LOW   = 8'd32;
  localparam logic [7:0] SYM_HIGH  = 8'd126;

  typedef struct packed {
    logic clr;
    logic append;
    logic load;
    logic div_step;
    logic div_init;
    logic push;
    logic pop;
    logic emit_err;
    logic emit_minus;
    logic emit_zero;
    logic emit_digit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic base_bad;
    logic in_zero;
    logic neg;
    logic mag_zero;
    logic div_last;
    logic depth_zero;
  } ctrl_sts_t;

endpackage

[hw/rtl/stcrd_datapath.sv]
// ----------------------------------------------------------------------------
// stcrd_datapath
// Alphabet store, bit-serial divider, digit stack and result register.
// ----------------------------------------------------------------------------
`include "signed_to_custom_radix_digits_macros.svh"

module stcrd_datapath #(
  parameter int MAX_BASE    = stcrd_pkg::DEF_MAX_BASE,
  parameter int VALUE_BITS  = stcrd_pkg::DEF_VALUE_BITS,
  parameter int DIGIT_DEPTH = stcrd_pkg::DEF_DIGIT_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  stcrd_pkg::ctrl_cmd_t         cmd,
  output stcrd_pkg::ctrl_sts_t         sts,
  input  logic [7:0]                   in_symbol,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output logic                         out_valid,
  output logic [6:0]                   out_character,
  output logic                         out_last,
  output logic                         out_status
);
  import stcrd_pkg::*;

  localparam int DW = $clog2(DIGIT_DEPTH + 1);
  localparam int AW = $clog2(DIGIT_DEPTH);
  localparam int BW = $clog2(VALUE_BITS);

  // alphabet state
  logic [ALPHA_DEPTH-1:0] seen_r;
  logic [CNT_W-1:0]       count_r;
  logic                   bad_r;
  logic [SYM_W-1:0]       alpha_mem_r [ALPHA_DEPTH];
  logic [SYM_W-1:0]       alpha_rd_r;

  // divider and stack
  logic [VALUE_BITS-1:0]  mag_r;
  logic                   neg_r;
  logic [CNT_W-1:0]       rem_r;
  logic [BW-1:0]          bit_cnt_r;
  logic [DW-1:0]          depth_r;
  logic [SYM_W-1:0]       stack_mem_r [DIGIT_DEPTH];
  logic [SYM_W-1:0]       stack_rd_r;

  // result register
  logic                   out_valid_r;
  logic [6:0]             out_chr_r;
  logic                   out_last_r;
  logic                   out_status_r;

  logic                   sym_ok;
  logic [VALUE_BITS-1:0]  in_mag;
  logic [CNT_W:0]         trial;
  logic [CNT_W:0]         diff;
  logic                   qbit;
  logic [DW-1:0]          depth_m1;

  assign sym_ok = (in_symbol != SYM_PLUS) && (in_symbol != SYM_MINUS) &&
                  (in_symbol >= SYM_LOW) && (in_symbol <= SYM_HIGH) &&
                  !seen_r[in_symbol[SYM_W-1:0]] &&
                  (count_r < CNT_W'(MAX_BASE));

  assign in_mag   = in_value[VALUE_BITS-1] ? (~in_value + VALUE_BITS'(1)) : in_value;
  assign trial    = {rem_r, mag_r[VALUE_BITS-1]};
  assign diff     = trial - {1'b0, count_r};
  assign qbit     = (trial >= {1'b0, count_r});
  assign depth_m1 = depth_r - DW'(1);

  assign sts.base_bad   = bad_r || (count_r < CNT_W'(2));
  assign sts.in_zero    = (in_value == '0);
  assign sts.neg        = neg_r;
  assign sts.mag_zero   = (mag_r == '0);
  assign sts.div_last   = (bit_cnt_r == '0);
  assign sts.depth_zero = (depth_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      count_r <= '0;
      bad_r   <= 1'b0;
    end else if (cmd.clr) begin
      seen_r  <= '0;
      count_r <= '0;
      bad_r   <= 1'b0;
    end else if (cmd.append) begin
      if (sym_ok) begin
        seen_r[in_symbol[SYM_W-1:0]] <= 1'b1;
        count_r                      <= count_r + CNT_W'(1);
      end else begin
        bad_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append && sym_ok) begin
      alpha_mem_r[count_r[SYM_W-1:0]] <= in_symbol[SYM_W-1:0];
    end
    alpha_rd_r <= alpha_mem_r[rem_r[SYM_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r     <= in_mag;
      neg_r     <= in_value[VALUE_BITS-1];
      rem_r     <= '0;
      bit_cnt_r <= BW'(VALUE_BITS - 1);
    end else if (cmd.div_init) begin
      rem_r     <= '0;
      bit_cnt_r <= BW'(VALUE_BITS - 1);
    end else if (cmd.div_step) begin
      mag_r     <= {mag_r[VALUE_BITS-2:0], qbit};
      rem_r     <= qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      bit_cnt_r <= bit_cnt_r - BW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else if (cmd.load) begin
      depth_r <= '0;
    end else if (cmd.push && (depth_r < DW'(DIGIT_DEPTH))) begin
      depth_r <= depth_r + DW'(1);
    end else if (cmd.pop) begin
      depth_r <= depth_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && (depth_r < DW'(DIGIT_DEPTH))) begin
      stack_mem_r[depth_r[AW-1:0]] <= alpha_rd_r;
    end
    stack_rd_r <= stack_mem_r[depth_m1[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_err || cmd.emit_minus || cmd.emit_zero || cmd.emit_digit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      out_chr_r    <= '0;
      out_last_r   <= 1'b1;
      out_status_r <= 1'b1;
    end else if (cmd.emit_minus) begin
      out_chr_r    <= SYM_MINUS[6:0];
      out_last_r   <= 1'b0;
      out_status_r <= 1'b0;
    end else if (cmd.emit_zero) begin
      out_chr_r    <= alpha_rd_r;
      out_last_r   <= 1'b1;
      out_status_r <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_chr_r    <= stack_rd_r;
      out_last_r   <= (depth_r == '0);
      out_status_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_chr_r;
  assign out_last      = out_last_r;
  assign out_status    = out_status_r;

  `STCRD_ASSERT_IMP(a_depth_bound, clk, rst_n, 1'b1, depth_r <= DW'(DIGIT_DEPTH))
  `STCRD_ASSERT_IMP(a_rem_below_base, clk, rst_n, cmd.div_step, rem_r < count_r)

endmodule

[hw/rtl/stcrd_ctrl.sv]
// ----------------------------------------------------------------------------
// stcrd_ctrl
// Sequencer for alphabet updates, digit divisions and digit output.
// ----------------------------------------------------------------------------
`include "signed_to_custom_radix_digits_macros.svh"

module stcrd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_opcode,
  input  stcrd_pkg::ctrl_sts_t sts,
  output stcrd_pkg::ctrl_cmd_t cmd
);
  import stcrd_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_ZERO    = 4'd1;
  localparam logic [3:0] ST_ZOUT    = 4'd2;
  localparam logic [3:0] ST_DIV     = 4'd3;
  localparam logic [3:0] ST_DRD     = 4'd4;
  localparam logic [3:0] ST_DWR     = 4'd5;
  localparam logic [3:0] ST_SIGN    = 4'd6;
  localparam logic [3:0] ST_POP_RD  = 4'd7;
  localparam logic [3:0] ST_POP_OUT = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_opcode)
            OP_CLEAR:  cmd.clr = 1'b1;
            OP_APPEND: cmd.append = 1'b1;
            OP_CONVERT: begin
              if (sts.base_bad) begin
                cmd.emit_err = 1'b1;
              end else begin
                cmd.load  = 1'b1;
                state_nxt = sts.in_zero ? ST_ZERO : ST_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ZERO: state_nxt = ST_ZOUT;
      ST_ZOUT: begin
        cmd.emit_zero = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_DRD;
        end
      end
      ST_DRD: state_nxt = ST_DWR;
      ST_DWR: begin
        cmd.push = 1'b1;
        if (sts.mag_zero) begin
          state_nxt = sts.neg ? ST_SIGN : ST_POP_RD;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_SIGN: begin
        cmd.emit_minus = 1'b1;
        state_nxt      = ST_POP_RD;
      end
      ST_POP_RD: begin
        cmd.pop   = 1'b1;
        state_nxt = ST_POP_OUT;
      end
      ST_POP_OUT: begin
        cmd.emit_digit = 1'b1;
        state_nxt      = sts.depth_zero ? ST_IDLE : ST_POP_RD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `STCRD_ASSERT_IMP(a_one_emit, clk, rst_n, 1'b1,
    $onehot0({cmd.emit_err, cmd.emit_minus, cmd.emit_zero, cmd.emit_digit}))
  `STCRD_ASSERT_IMP(a_alpha_frozen, clk, rst_n, busy, !(cmd.clr || cmd.append))
  `STCRD_ASSERT_NXT(a_div_runs, clk, rst_n, (state_r == ST_DIV) && !sts.div_last, state_r == ST_DIV)

endmodule

[hw/rtl/signed_to_custom_radix_digits.sv]
// ----------------------------------------------------------------------------
// signed_to_custom_radix_digits
// Signed integer to text in a digit alphabet built at run time.
// ----------------------------------------------------------------------------
// Usage: drive in_opcode, in_symbol and in_value with start high; the item
// transfers at a rising edge where start is high and busy is low.
// Opcode clear empties the alphabet, append adds one symbol (a refused symbol
// marks the base bad until the next clear); both give no result and leave
// busy low. Convert gives one error result when the base is bad or has fewer
// than two symbols, else an optional '-' and the digits most significant
// first, out_last on the final one. Each result is shown for one cycle with
// out_valid; the receiver cannot stall, so every result transfers.
// A single bit-serial divider forms each digit as the remainder of the
// magnitude; the digit is then looked up in the alphabet and stacked. Once
// the magnitude reaches zero, a '-' is emitted for a negative value, then
// the digits are popped and emitted. A convert holds busy high until its
// last result is formed; an error result leaves busy low.
// Results appear in the cycle after they are formed, in a registered stage.
// Reset empties the alphabet and clears the bad flag; no clearing pass.
// ----------------------------------------------------------------------------
module signed_to_custom_radix_digits #(
  parameter int MAX_BASE    = stcrd_pkg::DEF_MAX_BASE,
  parameter int VALUE_BITS  = stcrd_pkg::DEF_VALUE_BITS,
  parameter int DIGIT_DEPTH = stcrd_pkg::DEF_DIGIT_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_opcode,
  input  logic [7:0]                   in_symbol,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output logic                         out_valid,
  output logic [6:0]                   out_character,
  output logic                         out_last,
  output logic                         out_status
);
  import stcrd_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  stcrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_opcode (in_opcode),
    .sts       (sts),
    .cmd       (cmd)
  );

  stcrd_datapath #(
    .MAX_BASE    (MAX_BASE),
    .VALUE_BITS  (VALUE_BITS),
    .DIGIT_DEPTH (DIGIT_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_symbol     (in_symbol),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last),
    .out_status    (out_status)
  );

endmodule
